/* design/boxcar_derivative_fault_detector_unit_macros.svh */
`ifndef BOXCAR_DERIVATIVE_FAULT_DETECTOR_UNIT_MACROS_SVH
`define BOXCAR_DERIVATIVE_FAULT_DETECTOR_UNIT_MACROS_SVH

// Checks that only hold once the block is out of reset.
`define BDFD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("bdfd assertion failed");

// Checks that look at the reset itself.
`define BDFD_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("bdfd reset assertion failed");

`endif

/* design/bdfd_pkg.sv */
`default_nettype none

package bdfd_pkg;

  localparam int SAMPLE_W        = 16;
  localparam int ACC_W           = 24;
  localparam int THR_W           = 15;
  localparam int THR_RESET       = 2600;
  localparam int WINDOW_DEF      = 200;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int CFG_DATA_W      = 32;
  localparam int CFG_ADDR_W      = 3;

  typedef enum logic [0:0] {
    REG_FAULT_THRESHOLD = 1'b0,
    REG_UNUSED          = 1'b1
  } reg_idx_t;

endpackage

`default_nettype wire

/* design/boxcar_derivative_fault_detector_unit.sv */
// Boxcar-filtered derivative fault detector. Each input item is one signed
// accelerometer sample; each produces one result item holding the running sum
// x[n] - 2*x[n-WINDOW/2] + x[n-WINDOW] (the derivative scaled by WINDOW), a
// flag that the value lies outside +/- fault_threshold*WINDOW, and a sticky
// fault-latched flag that only reset clears. The block takes one item per clock
// cycle unless the output stalls, and the result of an item is registered and
// offered in the cycle after it is accepted; the accumulator update and the
// threshold compare feed the output register, while the two delay-line taps
// for the next item are read from the history memory in the same cycle. The
// delay line reads as zero until it has been filled once, so no clearing pass
// is needed after reset. fault_threshold sits at byte address 0 and should only
// be written while no items are in flight.
`default_nettype none

module boxcar_derivative_fault_detector_unit
  import bdfd_pkg::*;
#(
  parameter int WINDOW      = WINDOW_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic signed [SAMPLE_W-1:0]   in_sample,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic signed [ACC_W-1:0]           out_scaled_derivative,
  output logic                              out_fault_now,
  output logic                              out_fault_latched,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [CFG_ADDR_W-1:0]        paddr,
  input  wire logic [CFG_DATA_W-1:0]        pwdata,
  output logic [CFG_DATA_W-1:0]             prdata,
  output logic                              pready
);

`include "boxcar_derivative_fault_detector_unit_macros.svh"

  localparam int PTR_W = $clog2(WINDOW);
  localparam int HALF  = WINDOW / 2;
  localparam int LIM_W = THR_W + $clog2(WINDOW + 1);
  localparam int CMP_W = ((LIM_W > ACC_W) ? LIM_W : ACC_W) + 1;
  localparam int RAW_W = (SAMPLE_BITS > SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;

  // Configuration.
  logic [THR_W-1:0] thr_r;
  logic [LIM_W-1:0] limit_r;
  logic             cfg_wr;
  reg_idx_t         cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_t'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign prdata  = (cfg_idx == REG_FAULT_THRESHOLD) ? CFG_DATA_W'(thr_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r   <= THR_W'(THR_RESET);
      limit_r <= LIM_W'(THR_RESET * WINDOW);
    end else if (cfg_wr && cfg_idx == REG_FAULT_THRESHOLD) begin
      thr_r   <= pwdata[THR_W-1:0];
      limit_r <= LIM_W'(pwdata[THR_W-1:0]) * LIM_W'(WINDOW);
    end
  end

  // Handshake.
  logic accept;
  logic out_valid_r;

  assign in_stall  = out_valid_r && out_stall;
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  // Delay-line pointers and fill tracking.
  logic [PTR_W-1:0] wp_r, wp_inc, wp_nxt, mid_nxt;
  logic [PTR_W:0]   mid_sum;
  logic             full_r, full_nxt;
  logic             old_ok_r, mid_ok_r;

  always_comb begin
    wp_inc   = (wp_r == PTR_W'(WINDOW - 1)) ? '0 : wp_r + PTR_W'(1);
    wp_nxt   = accept ? wp_inc : wp_r;
    full_nxt = full_r || (accept && wp_r == PTR_W'(WINDOW - 1));
    mid_sum  = {1'b0, wp_nxt} + (PTR_W + 1)'(HALF);
    if (mid_sum >= (PTR_W + 1)'(WINDOW)) begin
      mid_sum = mid_sum - (PTR_W + 1)'(WINDOW);
    end
    mid_nxt  = mid_sum[PTR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r     <= '0;
      full_r   <= 1'b0;
      old_ok_r <= 1'b0;
      mid_ok_r <= 1'b0;
    end else begin
      wp_r     <= wp_nxt;
      full_r   <= full_nxt;
      // An entry has been written once the line is full or it lies behind
      // the write pointer in the first lap.
      old_ok_r <= full_nxt;
      mid_ok_r <= full_nxt || (mid_nxt < wp_nxt);
    end
  end

  // Sample history. The taps for the next item are read ahead; they never
  // coincide with the entry being written in the same cycle.
  logic [RAW_W-1:0]              raw;
  logic signed [SAMPLE_BITS-1:0] x;
  logic [SAMPLE_BITS-1:0]        hist_mem [WINDOW];
  logic signed [SAMPLE_BITS-1:0] old_rd_r, mid_rd_r;

  assign raw = RAW_W'($unsigned(in_sample));
  assign x   = raw[SAMPLE_BITS-1:0];

  always_ff @(posedge clk) begin
    if (accept) begin
      hist_mem[wp_r] <= x;
    end
    old_rd_r <= hist_mem[wp_nxt];
    mid_rd_r <= hist_mem[mid_nxt];
  end

  // Accumulator update and threshold compare.
  logic signed [ACC_W-1:0] acc_r, acc_nxt, x_ext, old_ext, mid_ext;
  logic signed [CMP_W-1:0] val_c, lim_c;
  logic                    fault_c;
  logic                    fault_latch_r;

  always_comb begin
    x_ext   = ACC_W'(x);
    old_ext = old_ok_r ? ACC_W'(old_rd_r) : '0;
    mid_ext = mid_ok_r ? ACC_W'(mid_rd_r) : '0;
    acc_nxt = acc_r + x_ext - (mid_ext <<< 1) + old_ext;
    val_c   = CMP_W'(acc_nxt);
    lim_c   = CMP_W'(limit_r);
    fault_c = (val_c > lim_c) || (val_c < -lim_c);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r         <= '0;
      fault_latch_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (accept) begin
        acc_r         <= acc_nxt;
        fault_latch_r <= fault_latch_r || fault_c;
        out_valid_r   <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_scaled_derivative <= acc_nxt;
      out_fault_now         <= fault_c;
      out_fault_latched     <= fault_latch_r || fault_c;
    end
  end

  `BDFD_ASSERT(a_stop_sticky, out_valid && out_fault_latched |=> out_fault_latched)
  `BDFD_ASSERT(a_fault_stops, out_valid && out_fault_now |-> out_fault_latched && fault_latch_r)
  `BDFD_ASSERT(a_full_taps, old_ok_r |-> mid_ok_r)
  `BDFD_ASSERT_RST(a_rst_clear, !rst_n |=> !out_valid_r && !fault_latch_r && acc_r == '0)

endmodule

`default_nettype wire
